// ----- sv/e2q_pkg.sv -----
`default_nettype none
package e2q_pkg;
  localparam int InWidth     = 17;
  localparam int OutWidth    = 16;
  localparam int OutFrac     = 14;
  localparam int Steps       = 16;
  localparam int ZWidth      = 33;
  localparam int XyWidth     = 33;
  localparam int HalfShift   = 16;
  localparam int RndShift    = 16;
  localparam int SincosW     = 17;

  localparam logic signed [ZWidth-1:0] HalfPi    = 33'sd1686629713;
  localparam logic signed [ZWidth-1:0] QuarterPi = 33'sd843314857;
  localparam logic signed [XyWidth-1:0] Gain     = 33'sd652032874;

  typedef logic signed [ZWidth-1:0] z_t;
  typedef logic signed [XyWidth-1:0] xy_t;
  typedef logic signed [SincosW-1:0] sc_t;

  typedef struct packed {
    xy_t x;
    xy_t y;
    z_t  z;
    logic [1:0] quad;
  } cordic_t;

  function automatic z_t atan_entry(input int i);
    unique case (i)
      0: atan_entry = 33'sd843314857;
      1: atan_entry = 33'sd497837829;
      2: atan_entry = 33'sd263043837;
      3: atan_entry = 33'sd133525159;
      4: atan_entry = 33'sd67021687;
      5: atan_entry = 33'sd33543516;
      6: atan_entry = 33'sd16775851;
      7: atan_entry = 33'sd8388437;
      8: atan_entry = 33'sd4194283;
      9: atan_entry = 33'sd2097149;
      10: atan_entry = 33'sd1048576;
      11: atan_entry = 33'sd524288;
      12: atan_entry = 33'sd262144;
      13: atan_entry = 33'sd131072;
      14: atan_entry = 33'sd65536;
      15: atan_entry = 33'sd32768;
      default: atan_entry = '0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ----- sv/e2q_sincos.sv -----
`default_nettype none
// Half-angle sine/cosine: fold stage, one CORDIC step per stage, map stage.
module e2q_sincos import e2q_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic signed [InWidth-1:0]  angle_i,
  output sc_t                             sin_o,
  output sc_t                             cos_o
);
  // theta in Q.30 is angle << 16; k = floor((theta + pi/4) / (pi/2)),
  // |theta| <= 4 rad so k in [-3,3]: pick by comparing with multiples.
  z_t theta;
  assign theta = z_t'(angle_i) <<< HalfShift;

  logic signed [3:0] k;
  z_t r;
  always_comb begin
    logic signed [36:0] t, lo;
    t = 37'(theta) + 37'(QuarterPi);
    k = -4'sd6;
    for (int j = -5; j <= 5; j++) begin
      lo = 37'(j) * 37'(HalfPi);
      if (t >= lo) k = 4'(j);
    end
    r = z_t'(37'(theta) - 37'(k) * 37'(HalfPi));
  end

  cordic_t st_q [0:Steps];
  always_ff @(posedge clk_i) begin
    st_q[0] <= '{x: Gain, y: '0, z: r, quad: k[1:0]};
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (st_q[i].z >= 0) begin
        st_q[i+1].x <= st_q[i].x - (st_q[i].y >>> i);
        st_q[i+1].y <= st_q[i].y + (st_q[i].x >>> i);
        st_q[i+1].z <= st_q[i].z - atan_entry(i);
      end else begin
        st_q[i+1].x <= st_q[i].x + (st_q[i].y >>> i);
        st_q[i+1].y <= st_q[i].y - (st_q[i].x >>> i);
        st_q[i+1].z <= st_q[i].z + atan_entry(i);
      end
      st_q[i+1].quad <= st_q[i].quad;
    end
  end

  xy_t s_d, c_d;
  always_comb begin
    unique case (st_q[Steps].quad)
      2'd0: begin s_d = st_q[Steps].y;  c_d = st_q[Steps].x;  end
      2'd1: begin s_d = st_q[Steps].x;  c_d = -st_q[Steps].y; end
      2'd2: begin s_d = -st_q[Steps].y; c_d = -st_q[Steps].x; end
      default: begin s_d = -st_q[Steps].x; c_d = st_q[Steps].y; end
    endcase
  end

  xy_t s_r, c_r;
  assign s_r = (s_d + (xy_t'(1) <<< (RndShift-1))) >>> RndShift;
  assign c_r = (c_d + (xy_t'(1) <<< (RndShift-1))) >>> RndShift;

  always_ff @(posedge clk_i) begin
    sin_o <= sc_t'(s_r);
    cos_o <= sc_t'(c_r);
  end
endmodule
`default_nettype wire

// ----- sv/e2q_combine.sv -----
`default_nettype none
// Triple products and saturation, 3 register stages.
module e2q_combine import e2q_pkg::*; (
  input  wire logic clk_i,
  input  wire sc_t  sr_i,
  input  wire sc_t  cr_i,
  input  wire sc_t  sp_i,
  input  wire sc_t  cp_i,
  input  wire sc_t  sy_i,
  input  wire sc_t  cy_i,
  output logic signed [OutWidth-1:0] qx_o,
  output logic signed [OutWidth-1:0] qy_o,
  output logic signed [OutWidth-1:0] qz_o,
  output logic signed [OutWidth-1:0] qw_o
);
  typedef logic signed [33:0] p_t;
  typedef logic signed [51:0] w_t;

  function automatic sc_t rnd_pair(input p_t p);
    p_t t;
    t = (p + (p_t'(1) <<< (OutFrac-1))) >>> OutFrac;
    return sc_t'(t);
  endfunction

  function automatic logic signed [OutWidth-1:0] fin(input w_t v);
    w_t t;
    w_t one;
    one = w_t'(1) <<< OutFrac;
    t = (v + (w_t'(1) <<< (OutFrac-1))) >>> OutFrac;
    if (t > one) t = one;
    if (t < -one) t = -one;
    return t[OutWidth-1:0];
  endfunction

  // stage 1: pair products
  sc_t srcp_q, crsp_q, crcp_q, srsp_q, sy_q, cy_q;
  always_ff @(posedge clk_i) begin
    srcp_q <= rnd_pair(p_t'(sr_i) * p_t'(cp_i));
    crsp_q <= rnd_pair(p_t'(cr_i) * p_t'(sp_i));
    crcp_q <= rnd_pair(p_t'(cr_i) * p_t'(cp_i));
    srsp_q <= rnd_pair(p_t'(sr_i) * p_t'(sp_i));
    sy_q <= sy_i;
    cy_q <= cy_i;
  end

  // stage 2: triple products
  p_t t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q, t8_q;
  always_ff @(posedge clk_i) begin
    t1_q <= p_t'(srcp_q) * p_t'(cy_q);
    t2_q <= p_t'(crsp_q) * p_t'(sy_q);
    t3_q <= p_t'(crsp_q) * p_t'(cy_q);
    t4_q <= p_t'(srcp_q) * p_t'(sy_q);
    t5_q <= p_t'(crcp_q) * p_t'(sy_q);
    t6_q <= p_t'(srsp_q) * p_t'(cy_q);
    t7_q <= p_t'(crcp_q) * p_t'(cy_q);
    t8_q <= p_t'(srsp_q) * p_t'(sy_q);
  end

  // stage 3: sum, round, clamp
  always_ff @(posedge clk_i) begin
    qx_o <= fin(w_t'(t1_q) - w_t'(t2_q));
    qy_o <= fin(w_t'(t3_q) + w_t'(t4_q));
    qz_o <= fin(w_t'(t5_q) - w_t'(t6_q));
    qw_o <= fin(w_t'(t7_q) + w_t'(t8_q));
  end
endmodule
`default_nettype wire

// ----- sv/euler_to_quaternion_top.sv -----
`default_nettype none
// Euler angles (roll, pitch, yaw; Q4.13 radians) to a unit quaternion
// (Q1.14, saturated to +-1). A request is taken whenever start is high;
// busy is always low, so one request can enter every cycle. Each result
// appears on the quat ports for exactly one cycle with done_o high, in
// request order; the receiver cannot stall, so it must take every result
// the cycle it is shown. The path runs through a fold stage, 16 CORDIC
// stages of one step each, a map stage and three product/saturate stages.
module euler_to_quaternion_top import e2q_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [InWidth-1:0]  roll_angle_i,
  input  wire logic signed [InWidth-1:0]  pitch_angle_i,
  input  wire logic signed [InWidth-1:0]  yaw_angle_i,
  output logic                            done_o,
  output logic signed [OutWidth-1:0]      quat_x_o,
  output logic signed [OutWidth-1:0]      quat_y_o,
  output logic signed [OutWidth-1:0]      quat_z_o,
  output logic signed [OutWidth-1:0]      quat_w_o
);
  localparam int Latency = Steps + 2 + 3;

  assign busy = 1'b0;

  sc_t sr, cr, sp, cp, sy, cy;

  e2q_sincos u_roll  (.clk_i, .angle_i(roll_angle_i),  .sin_o(sr), .cos_o(cr));
  e2q_sincos u_pitch (.clk_i, .angle_i(pitch_angle_i), .sin_o(sp), .cos_o(cp));
  e2q_sincos u_yaw   (.clk_i, .angle_i(yaw_angle_i),   .sin_o(sy), .cos_o(cy));

  e2q_combine u_comb (
    .clk_i, .sr_i(sr), .cr_i(cr), .sp_i(sp), .cp_i(cp), .sy_i(sy), .cy_i(cy),
    .qx_o(quat_x_o), .qy_o(quat_y_o), .qz_o(quat_z_o), .qw_o(quat_w_o)
  );

  // valid bits travel alongside the data
  logic [Latency-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start & ~busy};
    end
  end
  assign done_o = vld_q[Latency-1];
endmodule
`default_nettype wire

// ----- sv/e2q_checker.sv -----
`default_nettype none
module e2q_checker import e2q_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire logic signed [OutWidth-1:0] quat_x_o,
  input wire logic signed [OutWidth-1:0] quat_w_o
);
  localparam int Lat = Steps + 5;
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o) else $error("missing result");
  a_noinv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat)) else $error("spurious result");
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_x_o <= 16'sd16384 && quat_x_o >= -16'sd16384))
    else $error("x out of range");
  a_rngw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_w_o <= 16'sd16384 && quat_w_o >= -16'sd16384))
    else $error("w out of range");
endmodule

bind euler_to_quaternion_top e2q_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .quat_x_o, .quat_w_o
);
`default_nettype wire

// ----- bench/euler_to_quaternion_top_tb.sv -----
`default_nettype none
module euler_to_quaternion_top_tb import e2q_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency      = 21;
  localparam int StallLimit   = 2000;
  localparam int RandomCount  = 1100;
  localparam int AngleMax     = 51472;

  // Q.30 constants for the angle folding and the CORDIC.
  localparam longint Q30HalfPi    = 64'sd1686629713;
  localparam longint Q30QuarterPi = 64'sd843314857;
  localparam longint Q30Gain      = 64'sd652032874;

  typedef struct {
    logic signed [OutWidth-1:0] x;
    logic signed [OutWidth-1:0] y;
    logic signed [OutWidth-1:0] z;
    logic signed [OutWidth-1:0] w;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [InWidth-1:0] roll_angle_i = '0;
  logic signed [InWidth-1:0] pitch_angle_i = '0;
  logic signed [InWidth-1:0] yaw_angle_i = '0;
  logic done_o;
  logic signed [OutWidth-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t quat_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  euler_to_quaternion_top uut (
    .clk_i, .rst_ni, .start, .busy,
    .roll_angle_i, .pitch_angle_i, .yaw_angle_i,
    .done_o, .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Round-half-up shift; SV >>> on a signed longint is already arithmetic.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint arctan_q30(int i);
    case (i)
      0: return 843314857;   1: return 497837829;   2: return 263043837;
      3: return 133525159;   4: return 67021687;    5: return 33543516;
      6: return 16775851;    7: return 8388437;     8: return 4194283;
      9: return 2097149;     default: return longint'(1) << (30 - i);
    endcase
  endfunction

  // Sine and cosine of half the angle, Q1.14.
  function automatic void half_angle_sincos(input logic signed [InWidth-1:0] ang,
                                            output longint s, output longint c);
    longint theta, n, k, z, x, y, dx, dy, ps, pc;
    theta = longint'(ang) <<< HalfShift;
    n = theta + Q30QuarterPi;
    k = n / Q30HalfPi;
    if ((n % Q30HalfPi) != 0 && n < 0) k--;
    z = theta - k * Q30HalfPi;
    x = Q30Gain;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    case (k & 3)
      0: begin ps = y;  pc = x;  end
      1: begin ps = x;  pc = -y; end
      2: begin ps = -y; pc = -x; end
      default: begin ps = -x; pc = y; end
    endcase
    s = round_shift(ps, 30 - OutFrac);
    c = round_shift(pc, 30 - OutFrac);
  endfunction

  function automatic longint triple_product(longint a, longint b, longint c);
    return round_shift(a * b, OutFrac) * c;
  endfunction

  function automatic logic signed [OutWidth-1:0] round_saturate(longint wide);
    longint v, one;
    one = longint'(1) << OutFrac;
    v = round_shift(wide, OutFrac);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[OutWidth-1:0];
  endfunction

  function automatic quat_t predict_quaternion(logic signed [InWidth-1:0] r,
                                               logic signed [InWidth-1:0] p,
                                               logic signed [InWidth-1:0] yw);
    longint sr, cr, sp, cp, sy, cy;
    quat_t q;
    half_angle_sincos(r, sr, cr);
    half_angle_sincos(p, sp, cp);
    half_angle_sincos(yw, sy, cy);
    q.x = round_saturate(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
    q.y = round_saturate(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
    q.z = round_saturate(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
    q.w = round_saturate(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
    return q;
  endfunction

  // Sends one request; an optional burst of idle cycles goes in front of it.
  // start stays high across back-to-back requests.
  task automatic send_angles(input logic signed [InWidth-1:0] r,
                             input logic signed [InWidth-1:0] p,
                             input logic signed [InWidth-1:0] yw);
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(19, 1)) @(negedge clk_i);
    end
    start <= 1'b1;
    roll_angle_i <= r;
    pitch_angle_i <= p;
    yaw_angle_i <= yw;
    do @(posedge clk_i); while (busy);
    quat_queue.push_back(predict_quaternion(r, p, yw));
    @(negedge clk_i);
  endtask

  function automatic logic signed [InWidth-1:0] random_angle();
    case ($urandom_range(9))
      0: return InWidth'($urandom);                       // any pattern, beyond 2 pi
      1: return InWidth'($urandom_range(2 * AngleMax) - AngleMax);
      2: return InWidth'($urandom_range(64) - 32);        // near zero
      default: return InWidth'($urandom_range(2 * AngleMax) - AngleMax);
    endcase
  endfunction

  // Result checker: strobe sampled at the rising edge, compared with oldest.
  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        if (quat_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%0d", quat_x_o);
        end else begin
          exp_q = quat_queue.pop_front();
          if (quat_x_o !== exp_q.x || quat_y_o !== exp_q.y ||
              quat_z_o !== exp_q.z || quat_w_o !== exp_q.w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       exp_q.x, exp_q.y, exp_q.z, exp_q.w,
                       quat_x_o, quat_y_o, quat_z_o, quat_w_o);
          end
        end
      end
      if (idle_cycles > StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Field extremes, zero, both signs of pi, full-width patterns.
  task automatic test_extremes();
    logic signed [InWidth-1:0] corners[8];
    corners = '{17'sd0, 17'sd51472, -17'sd51472, 17'sd25736, -17'sd25736,
                17'sd65535, -17'sd65536, 17'sd12868};
    foreach (corners[i]) send_angles(corners[i], corners[(i + 3) % 8],
                                     corners[(i + 5) % 8]);
    send_angles(17'sd1, -17'sd1, 17'sd0);
    send_angles(-17'sd65536, -17'sd65536, -17'sd65536);
    send_angles(17'sd65535, 17'sd65535, 17'sd65535);
  endtask

  // Rotations at quadrant boundaries, about roll alone or about pitch and yaw together, where saturation can bite.
  task automatic test_single_axis();
    logic signed [InWidth-1:0] a;
    for (int k = -4; k <= 4; k++) begin
      a = InWidth'(k * 12868);
      case (k & 1)
        0: send_angles(a, 17'sd0, 17'sd0);
        default: send_angles(17'sd0, a, a);
      endcase
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < RandomCount; i++) begin
      if (i == RandomCount - 150) gaps_on = 1'b0;   // back-to-back at the end
      send_angles(random_angle(), random_angle(), random_angle());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_single_axis();
    test_random();
    start <= 1'b0;
    while (quat_queue.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
